// ===== hdl/saturation_contrast_adjust_unit_defines.svh =====
// assertion macros used by saturation_contrast_adjust_unit.sv
`ifndef SATURATION_CONTRAST_ADJUST_UNIT_DEFINES_SVH
`define SATURATION_CONTRAST_ADJUST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define SCA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define SCA_ASSERT_IMP(label, clk, rst, ante, cons)
`define SCA_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/sca_pkg.sv =====
`default_nettype none

package sca_pkg;

  localparam int ByteW   = 8;
  localparam int GainW   = 12;
  localparam int LumaW   = 16;
  localparam int LumaSumW = 24;
  localparam int CfgIdxW = 1;

  // rec.601 weights in q16, they sum to 65536
  localparam logic [LumaSumW-1:0] LumaWr = 24'd19595;
  localparam logic [LumaSumW-1:0] LumaWg = 24'd38470;
  localparam logic [LumaSumW-1:0] LumaWb = 24'd7471;

  localparam logic [GainW-1:0] GainOne = 12'd256;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] REG_SATURATION_GAIN = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_CONTRAST_GAIN   = 1'd1;

  // per-stage advance enables
  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } sca_adv_t;

endpackage

`default_nettype wire

// ===== hdl/sca_in_if.sv =====
`default_nettype none

interface sca_in_if import sca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] red_in;
  logic [ByteW-1:0] green_in;
  logic [ByteW-1:0] blue_in;
  logic [ByteW-1:0] alpha_in;
  logic             frame_end_in;

  modport source (
    output valid, red_in, green_in, blue_in, alpha_in, frame_end_in,
    input  ready
  );
  modport sink (
    input  valid, red_in, green_in, blue_in, alpha_in, frame_end_in,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/sca_out_if.sv =====
`default_nettype none

interface sca_out_if import sca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] red_out;
  logic [ByteW-1:0] green_out;
  logic [ByteW-1:0] blue_out;
  logic [ByteW-1:0] alpha_out;
  logic             frame_end_out;

  modport source (
    output valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/saturation_contrast_adjust_unit.sv =====
// an accepted input word passes stages 0 to 4 (luma, saturation, re-center, contrast, clamp) to its output word
// throughput: one pixel per clock while pixel_out.ready is high, bounded otherwise only by the five-stage pipeline
// back-pressure frees a stage as soon as the one after it moves, so bubbles are squeezed out
// reset (rst, synchronous, active high) empties the pipeline and sets both gains to 1.0
`default_nettype none

`include "saturation_contrast_adjust_unit_defines.svh"

module saturation_contrast_adjust_unit import sca_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // config write port
  input  wire logic               cfg_write,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [GainW-1:0]   cfg_data,
  // pixel streams
  sca_in_if.sink                  pixel_in,
  sca_out_if.source               pixel_out
);

  localparam int Stages = 5;

  // gain registers, q4.8
  logic [GainW-1:0] sat_gain;
  logic [GainW-1:0] con_gain;

  // one valid bit per stage, stage 4 is the output register
  logic [Stages-1:0] valid;
  sca_adv_t          adv;

  // luma stage outputs
  logic [LumaW-1:0] luma;
  logic [ByteW-1:0] red_q;
  logic [ByteW-1:0] green_q;
  logic [ByteW-1:0] blue_q;

  // alpha and frame-end ride alongside the colour math
  logic [ByteW-1:0] alpha_pipe [Stages];
  logic             fe_pipe    [Stages];

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_gain <= GainOne;
      con_gain <= GainOne;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SATURATION_GAIN: sat_gain <= cfg_data;
        REG_CONTRAST_GAIN:   con_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its word moves on this cycle
  assign adv.s4 = !valid[4] || pixel_out.ready;
  assign adv.s3 = !valid[3] || adv.s4;
  assign adv.s2 = !valid[2] || adv.s3;
  assign adv.s1 = !valid[1] || adv.s2;
  assign adv.s0 = !valid[0] || adv.s1;

  assign pixel_in.ready = adv.s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv.s0) valid[0] <= pixel_in.valid;
      if (adv.s1) valid[1] <= valid[0];
      if (adv.s2) valid[2] <= valid[1];
      if (adv.s3) valid[3] <= valid[2];
      if (adv.s4) valid[4] <= valid[3];
    end
  end

  // sideband delay line, no reset needed on payload
  always_ff @(posedge clk) begin
    if (adv.s0) begin
      alpha_pipe[0] <= pixel_in.alpha_in;
      fe_pipe[0]    <= pixel_in.frame_end_in;
    end
    if (adv.s1) begin
      alpha_pipe[1] <= alpha_pipe[0];
      fe_pipe[1]    <= fe_pipe[0];
    end
    if (adv.s2) begin
      alpha_pipe[2] <= alpha_pipe[1];
      fe_pipe[2]    <= fe_pipe[1];
    end
    if (adv.s3) begin
      alpha_pipe[3] <= alpha_pipe[2];
      fe_pipe[3]    <= fe_pipe[2];
    end
    if (adv.s4) begin
      alpha_pipe[4] <= alpha_pipe[3];
      fe_pipe[4]    <= fe_pipe[3];
    end
  end

  // stage 0: rec.601 luma in q8
  sca_luma u_luma (
    .clk     (clk),
    .adv     (adv),
    .red     (pixel_in.red_in),
    .green   (pixel_in.green_in),
    .blue    (pixel_in.blue_in),
    .luma    (luma),
    .red_q   (red_q),
    .green_q (green_q),
    .blue_q  (blue_q)
  );

  // stages 1..4 per channel: saturation multiply, re-center,
  // contrast multiply, floor and clamp
  // with both gains at 1.0 the math is exact, so pixels come out untouched
  sca_chan u_chan_red (
    .clk      (clk),
    .adv      (adv),
    .chan     (red_q),
    .luma     (luma),
    .sat_gain (sat_gain),
    .con_gain (con_gain),
    .result   (pixel_out.red_out)
  );

  sca_chan u_chan_green (
    .clk      (clk),
    .adv      (adv),
    .chan     (green_q),
    .luma     (luma),
    .sat_gain (sat_gain),
    .con_gain (con_gain),
    .result   (pixel_out.green_out)
  );

  sca_chan u_chan_blue (
    .clk      (clk),
    .adv      (adv),
    .chan     (blue_q),
    .luma     (luma),
    .sat_gain (sat_gain),
    .con_gain (con_gain),
    .result   (pixel_out.blue_out)
  );

  assign pixel_out.valid         = valid[4];
  assign pixel_out.alpha_out     = alpha_pipe[4];
  assign pixel_out.frame_end_out = fe_pipe[4];

  // a word in the luma stage moves forward when the next stage loads
  `SCA_ASSERT_NXT(a_luma_moves, clk, rst, valid[0] && adv.s1, valid[1])
  // a blocked middle stage keeps its word
  `SCA_ASSERT_NXT(a_mid_holds, clk, rst, valid[2] && !adv.s3, valid[2])
  // input is refused only while the first stage is occupied
  `SCA_ASSERT_IMP(a_refuse_full, clk, rst, !pixel_in.ready, valid[0])

endmodule

`default_nettype wire

// ===== hdl/sca_luma.sv =====
`default_nettype none

module sca_luma import sca_pkg::*; (
  input  wire logic             clk,
  input  wire sca_adv_t         adv,
  input  wire logic [ByteW-1:0] red,
  input  wire logic [ByteW-1:0] green,
  input  wire logic [ByteW-1:0] blue,
  output logic      [LumaW-1:0] luma,
  output logic      [ByteW-1:0] red_q,
  output logic      [ByteW-1:0] green_q,
  output logic      [ByteW-1:0] blue_q
);

  logic [LumaSumW-1:0] luma_sum;

  // weighted sum in q16, keep 8 fraction bits
  assign luma_sum = LumaWr * LumaSumW'(red) + LumaWg * LumaSumW'(green)
                  + LumaWb * LumaSumW'(blue);

  always_ff @(posedge clk) begin
    if (adv.s0) begin
      luma    <= luma_sum[LumaSumW-1:8];
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sca_chan.sv =====
`default_nettype none

module sca_chan import sca_pkg::*; (
  input  wire logic             clk,
  input  wire sca_adv_t         adv,
  input  wire logic [ByteW-1:0] chan,
  input  wire logic [LumaW-1:0] luma,
  input  wire logic [GainW-1:0] sat_gain,
  input  wire logic [GainW-1:0] con_gain,
  output logic      [ByteW-1:0] result
);

  logic signed [17:0] diff;
  logic signed [30:0] sat_full;
  logic signed [28:0] sat_prod;
  logic        [LumaW-1:0] luma_d;
  logic signed [21:0] sat_val;
  logic signed [21:0] centered;
  logic signed [34:0] con_full;
  logic signed [33:0] con_prod;
  logic signed [26:0] con_val;
  logic signed [18:0] whole;
  logic        [ByteW-1:0] clamped;

  // chroma offset from luma, scaled by saturation
  assign diff     = $signed({2'b00, chan, 8'h00}) - $signed({2'b00, luma});
  assign sat_full = diff * $signed({1'b0, sat_gain});

  // floored product back to q8, added back onto luma
  assign sat_val = $signed({6'b0, luma_d}) + 22'($signed(sat_prod[28:8]));

  assign con_full = centered * $signed({1'b0, con_gain});

  assign con_val = 27'($signed(con_prod[33:8])) + 27'sd32768;
  assign whole   = con_val[26:8];

  always_comb begin
    if (whole[18]) begin
      clamped = '0;
    end else if (|whole[17:8]) begin
      clamped = '1;
    end else begin
      clamped = whole[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      sat_prod <= sat_full[28:0];
      luma_d   <= luma;
    end
    if (adv.s2) begin
      centered <= sat_val - 22'sd32768;
    end
    if (adv.s3) begin
      con_prod <= con_full[33:0];
    end
    if (adv.s4) begin
      result <= clamped;
    end
  end

endmodule

`default_nettype wire
